/* hw/rtl/cbl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbl_pkg: shared types and constants for the circular byte log
// Request and response payload structs, the mode code and reset values.
// ----------------------------------------------------------------------------
package cbl_pkg;

   localparam int BYTE_W            = 8;
   localparam int CSR_W             = 14;
   localparam int DEF_RING_DEPTH    = 8192;
   localparam logic [CSR_W-1:0] BUFFER_SIZE_RESET = 14'd8192;

   // what a request asks for
   typedef enum logic {
      MODE_WRITE = 1'b0,
      MODE_READ  = 1'b1
   } cbl_mode_type;

   typedef struct packed {
      cbl_mode_type      mode;
      logic [BYTE_W-1:0] data_byte;
      logic [CSR_W-1:0]  back_offset;
   } cbl_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_byte;
      logic              in_range;
      logic [CSR_W-1:0]  stored_count;
      logic              overflowed;
   } cbl_rsp_type;

   // log status as it stands after one request
   typedef struct packed {
      logic             in_range;
      logic [CSR_W-1:0] stored_count;
      logic             overflowed;
   } cbl_status_type;

endpackage
`default_nettype wire

/* hw/rtl/circular_byte_log.sv */
// A response is valid in the cycle after its request is accepted.
// Throughput: one request per cycle, limited by the single RAM port; a
// request is taken while the response register is empty or being drained.
// Reset: synchronous; clears pointer, held count, overflow flag and response
// valid flag, and sets the ring size to its default. Log RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circular_byte_log: byte log kept in a ring of configurable size
// Write requests append a byte, read requests fetch one by back offset.
// ----------------------------------------------------------------------------
module circular_byte_log #(
   parameter int RING_DEPTH = cbl_pkg::DEF_RING_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_enable,
   input  wire logic [cbl_pkg::CSR_W-1:0] csr_write_data,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire cbl_pkg::cbl_req_type      req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output cbl_pkg::cbl_rsp_type           rsp_payload
);
   import cbl_pkg::*;

   localparam int AW = $clog2(RING_DEPTH);

   logic              accept;
   logic              mem_wr_en, mem_rd_en;
   logic [AW-1:0]     mem_addr;
   logic [BYTE_W-1:0] rd_data;
   cbl_status_type    status, status_ff;
   logic              rsp_valid_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   cbl_ctrl #(
      .RING_DEPTH (RING_DEPTH),
      .AW         (AW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .req              (req_payload),
      .mem_wr_en        (mem_wr_en),
      .mem_rd_en        (mem_rd_en),
      .mem_addr         (mem_addr),
      .status           (status)
   );

   cbl_ram #(
      .DEPTH (RING_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (req_payload.data_byte),
      .rd_data (rd_data)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_payload.read_byte    = status_ff.in_range ? rd_data : '0;
   assign rsp_payload.in_range     = status_ff.in_range;
   assign rsp_payload.stored_count = status_ff.stored_count;
   assign rsp_payload.overflowed   = status_ff.overflowed;

`ifndef SYNTHESIS
   a_accept_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request produced no response");

   a_stall_blocks_req : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

   a_write_no_data : assert property (@(posedge clock) disable iff (reset)
      accept && (req_payload.mode == MODE_WRITE) |=>
         !rsp_payload.in_range && (rsp_payload.read_byte == '0))
      else $error("write request returned read data");
`endif

endmodule
`default_nettype wire

/* hw/rtl/cbl_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbl_ram: log byte storage
// Single port memory, one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module cbl_ram #(
   parameter int DEPTH = cbl_pkg::DEF_RING_DEPTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              addr,
   input  wire logic [cbl_pkg::BYTE_W-1:0] wr_data,
   output logic      [cbl_pkg::BYTE_W-1:0] rd_data
);
   import cbl_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hw/rtl/cbl_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbl_ctrl: ring pointer, held count and overflow tracking
// Holds the size register, computes the RAM address for each request and
// the status that goes with its response.
// ----------------------------------------------------------------------------
module cbl_ctrl #(
   parameter int RING_DEPTH = cbl_pkg::DEF_RING_DEPTH,
   parameter int AW         = $clog2(RING_DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_enable,
   input  wire logic [cbl_pkg::CSR_W-1:0] csr_write_data,
   input  wire logic                      accept,
   input  wire cbl_pkg::cbl_req_type      req,
   output logic                           mem_wr_en,
   output logic                           mem_rd_en,
   output logic      [AW-1:0]             mem_addr,
   output cbl_pkg::cbl_status_type        status
);
   import cbl_pkg::*;

   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam int SW = (CW > CSR_W) ? CW : CSR_W;

   logic [CSR_W-1:0] size_ff;
   logic [AW-1:0]    wp_ff, wp_in;
   logic [CW-1:0]    held_ff, held_in;
   logic             ovf_ff, ovf_in;

   logic [SW-1:0]    size_ext, eff_size, offset, wp_ext;
   logic [SW:0]      idx_sum, idx;
   logic             is_write, hit;

   // effective size, clamped to 1..RING_DEPTH
   always_comb begin
      size_ext = SW'(size_ff);
      priority if (size_ext == '0) begin
         eff_size = SW'(1);
      end else if (size_ext > SW'(RING_DEPTH)) begin
         eff_size = SW'(RING_DEPTH);
      end else begin
         eff_size = size_ext;
      end
   end

   // read index: offset back from the newest byte, wrapped at the size
   always_comb begin
      is_write = (req.mode == MODE_WRITE);
      offset   = SW'(req.back_offset);
      wp_ext   = SW'(wp_ff);
      hit      = !is_write && (offset != '0) && (offset <= SW'(held_ff));
      idx_sum  = (SW+1)'(wp_ext) + (SW+1)'(eff_size) - (SW+1)'(offset);
      idx      = (idx_sum >= (SW+1)'(eff_size)) ? idx_sum - (SW+1)'(eff_size) : idx_sum;
   end

   // state after a write
   always_comb begin
      wp_in   = wp_ff;
      held_in = held_ff;
      ovf_in  = ovf_ff;
      if (is_write) begin
         wp_in = (wp_ext + SW'(1) >= eff_size) ? '0 : wp_ff + AW'(1);
         if (SW'(held_ff) < eff_size) begin
            held_in = held_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= BUFFER_SIZE_RESET;
         wp_ff   <= '0;
         held_ff <= '0;
         ovf_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         size_ff <= csr_write_data;
         wp_ff   <= '0;
         held_ff <= '0;
         ovf_ff  <= 1'b0;
      end else if (accept) begin
         wp_ff   <= wp_in;
         held_ff <= held_in;
         ovf_ff  <= ovf_in;
      end
   end

   // RAM access and response status
   assign mem_wr_en           = accept && is_write;
   assign mem_rd_en           = accept && !is_write;
   assign mem_addr            = is_write ? wp_ff : idx[AW-1:0];
   assign status.in_range     = hit;
   assign status.stored_count = CSR_W'(held_in);
   assign status.overflowed   = ovf_in;

endmodule
`default_nettype wire
